// ===== hdl/lcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared constants and types of the lcm complement finder.
// ----------------------------------------------------------------------------
package lcf_pkg;

   localparam int VALUE_BITS_DEFAULT = 24;

   // working words held in the scratch memory
   typedef enum logic [1:0] {
      SLOT_REST_C = 2'd0,
      SLOT_REST_A = 2'd1,
      SLOT_PROD   = 2'd2
   } slot_type;

endpackage

// ===== hdl/lcf_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_divider
// Restoring radix-2 divider, one quotient bit per cycle. A start pulse
// latches the operands; done pulses when quotient and remainder are valid.
// ----------------------------------------------------------------------------
module lcf_divider #(
   parameter int VALUE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [VALUE_BITS-1:0] remainder
);

   localparam int CW = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [VALUE_BITS-1:0] dvs_ff, dvs_in;
   logic [VALUE_BITS:0]   rem_shift;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;

   assign rem_shift = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign diff      = rem_shift - {1'b0, dvs_ff};
   assign fits      = ~diff[VALUE_BITS];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(VALUE_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/lcm_complement_finder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_complement_finder_top
// Smallest b with lcm(a, b) = c, found by trial division of c.
//
// The req channel carries one word (base a, target c); the rsp channel
// returns one word per request: the complement b, or no_solution when c is
// not a multiple of a (complement 0). A zero target gives complement 0.
// One request is worked at a time; req_ready is high only while idle.
// Work runs as steps: the divisibility check and setup, then one trial
// division per trial divisor d with d*d <= rest of c, extra divisions of
// c or a when a prime is found, a start on a and a fold of the prime into
// the product, and a finishing step. Run time is set by the shared radix-2
// divider and the scratch memory, with one read and one write port, that
// holds rest of c, rest of a and the running product.
// A finished result waits in the rsp register while the receiver stalls;
// the next request is taken once the result has been stored there.
// Reset is synchronous: it returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module lcm_complement_finder_top #(
   parameter int VALUE_BITS = lcf_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_base_value,
   input  logic [VALUE_BITS-1:0] req_lcm_target,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_complement,
   output logic                  rsp_no_solution
);

   import lcf_pkg::*;

   localparam int W  = VALUE_BITS;
   localparam int DW = (VALUE_BITS + 1) / 2 + 1;
   localparam int SW = VALUE_BITS + 2;
   localparam int EW = $clog2(VALUE_BITS + 1);

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_CHECK  = 16'h0002,
      ST_MODA   = 16'h0004,
      ST_INIT_A = 16'h0008,
      ST_INIT_P = 16'h0010,
      ST_RDC    = 16'h0020,
      ST_CMP    = 16'h0040,
      ST_DIVC   = 16'h0080,
      ST_RDA    = 16'h0100,
      ST_DIVA0  = 16'h0200,
      ST_DIVA   = 16'h0400,
      ST_LRDA   = 16'h0800,
      ST_LCMPA  = 16'h1000,
      ST_RDP    = 16'h2000,
      ST_MUL    = 16'h4000,
      ST_DONE   = 16'h8000
   } state_type;

   state_type       state_ff, state_in;
   logic [W-1:0]    a_ff, a_in;
   logic [W-1:0]    c_ff, c_in;
   logic [DW-1:0]   d_ff, d_in;
   logic [SW-1:0]   dsq_ff, dsq_in;
   logic [W-1:0]    power_ff, power_in;
   logic [EW-1:0]   ec_ff, ec_in;
   logic [EW-1:0]   ea_ff, ea_in;
   logic            found_ff, found_in;
   logic            last_ff, last_in;
   logic [W-1:0]    res_comp_ff, res_comp_in;
   logic            res_none_ff, res_none_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]    rsp_comp_ff, rsp_comp_in;
   logic            rsp_none_ff, rsp_none_in;

   logic [W-1:0]    scratch_mem [0:2];
   logic [W-1:0]    rdata_ff;
   logic            rd_en;
   slot_type        rd_addr;
   logic            wr_en;
   slot_type        wr_addr;
   logic [W-1:0]    wr_data;

   logic            div_start;
   logic [W-1:0]    div_dvd;
   logic [W-1:0]    div_dvs;
   logic            div_done;
   logic [W-1:0]    div_quo;
   logic [W-1:0]    div_rem;

   logic [W-1:0]    d_ext;
   logic [2*W-1:0]  pow_full;
   logic [2*W-1:0]  prod_full;
   logic [W-1:0]    prod_new;
   logic            out_free;

   lcf_divider #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign d_ext     = {{(W-DW){1'b0}}, d_ff};
   assign pow_full  = power_ff * d_ext;
   assign prod_full = rdata_ff * power_ff;
   assign prod_new  = (ea_ff != ec_ff) ? prod_full[W-1:0] : rdata_ff;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      dsq_in       = dsq_ff;
      power_in     = power_ff;
      ec_in        = ec_ff;
      ea_in        = ea_ff;
      found_in     = found_ff;
      last_in      = last_ff;
      res_comp_in  = res_comp_ff;
      res_none_in  = res_none_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_comp_in  = rsp_comp_ff;
      rsp_none_in  = rsp_none_ff;
      rd_en        = 1'b0;
      rd_addr      = SLOT_REST_C;
      wr_en        = 1'b0;
      wr_addr      = SLOT_PROD;
      wr_data      = '0;
      div_start    = 1'b0;
      div_dvd      = rdata_ff;
      div_dvs      = d_ext;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_base_value;
               c_in     = req_lcm_target;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (c_ff == '0) begin
               res_comp_in = '0;
               res_none_in = 1'b0;
               state_in    = ST_DONE;
            end else if (a_ff == '0) begin
               res_comp_in = '0;
               res_none_in = 1'b1;
               state_in    = ST_DONE;
            end else begin
               div_start = 1'b1;
               div_dvd   = c_ff;
               div_dvs   = a_ff;
               state_in  = ST_MODA;
            end
         end
         ST_MODA: begin
            if (div_done) begin
               if (div_rem != '0) begin
                  res_comp_in = '0;
                  res_none_in = 1'b1;
                  state_in    = ST_DONE;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = SLOT_REST_C;
                  wr_data  = c_ff;
                  state_in = ST_INIT_A;
               end
            end
         end
         ST_INIT_A: begin
            wr_en    = 1'b1;
            wr_addr  = SLOT_REST_A;
            wr_data  = a_ff;
            state_in = ST_INIT_P;
         end
         ST_INIT_P: begin
            wr_en    = 1'b1;
            wr_addr  = SLOT_PROD;
            wr_data  = W'(1);
            d_in     = DW'(2);
            dsq_in   = SW'(4);
            power_in = W'(1);
            ec_in    = '0;
            ea_in    = '0;
            found_in = 1'b0;
            last_in  = 1'b0;
            state_in = ST_RDC;
         end
         ST_RDC: begin
            rd_en    = 1'b1;
            rd_addr  = SLOT_REST_C;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (dsq_ff > {2'b00, rdata_ff}) begin
               last_in = 1'b1;
               ea_in   = '0;
               if (rdata_ff > W'(1)) begin
                  power_in = rdata_ff;
                  ec_in    = EW'(1);
                  state_in = ST_LRDA;
               end else begin
                  ec_in    = '0;
                  state_in = ST_RDP;
               end
            end else begin
               div_start = 1'b1;
               div_dvd   = rdata_ff;
               state_in  = ST_DIVC;
            end
         end
         ST_DIVC: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  wr_en     = 1'b1;
                  wr_addr   = SLOT_REST_C;
                  wr_data   = div_quo;
                  power_in  = pow_full[W-1:0];
                  ec_in     = ec_ff + EW'(1);
                  found_in  = 1'b1;
                  div_start = 1'b1;
                  div_dvd   = div_quo;
               end else if (found_ff) begin
                  state_in = ST_RDA;
               end else begin
                  d_in     = d_ff + DW'(1);
                  dsq_in   = dsq_ff + {{(SW-DW-1){1'b0}}, d_ff, 1'b1};
                  state_in = ST_RDC;
               end
            end
         end
         ST_RDA: begin
            rd_en    = 1'b1;
            rd_addr  = SLOT_REST_A;
            state_in = ST_DIVA0;
         end
         ST_DIVA0: begin
            div_start = 1'b1;
            div_dvd   = rdata_ff;
            state_in  = ST_DIVA;
         end
         ST_DIVA: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  wr_en     = 1'b1;
                  wr_addr   = SLOT_REST_A;
                  wr_data   = div_quo;
                  ea_in     = ea_ff + EW'(1);
                  div_start = 1'b1;
                  div_dvd   = div_quo;
               end else begin
                  state_in = ST_RDP;
               end
            end
         end
         ST_LRDA: begin
            rd_en    = 1'b1;
            rd_addr  = SLOT_REST_A;
            state_in = ST_LCMPA;
         end
         ST_LCMPA: begin
            if (rdata_ff == power_ff) begin
               ea_in = EW'(1);
            end
            state_in = ST_RDP;
         end
         ST_RDP: begin
            rd_en    = 1'b1;
            rd_addr  = SLOT_PROD;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (last_ff) begin
               res_comp_in = prod_new;
               res_none_in = 1'b0;
               state_in    = ST_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = SLOT_PROD;
               wr_data  = prod_new;
               d_in     = d_ff + DW'(1);
               dsq_in   = dsq_ff + {{(SW-DW-1){1'b0}}, d_ff, 1'b1};
               power_in = W'(1);
               ec_in    = '0;
               ea_in    = '0;
               found_in = 1'b0;
               state_in = ST_RDC;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_comp_in  = res_comp_ff;
               rsp_none_in  = res_none_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         scratch_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= scratch_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      dsq_ff      <= dsq_in;
      power_ff    <= power_in;
      ec_ff       <= ec_in;
      ea_ff       <= ea_in;
      found_ff    <= found_in;
      last_ff     <= last_in;
      res_comp_ff <= res_comp_in;
      res_none_ff <= res_none_in;
      rsp_comp_ff <= rsp_comp_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_complement  = rsp_comp_ff;
   assign rsp_no_solution = rsp_none_ff;

`ifndef NO_ASSERTIONS
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("scratch read and write hit the same entry");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MODA || state_ff == ST_DIVC || state_ff == ST_DIVA))
      else $error("divider finished outside a waiting state");

   a_exp_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDP) |-> (ea_ff <= ec_ff))
      else $error("exponent of base exceeds exponent of target");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CHECK))
      else $error("accepted word not checked next");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_solution) |-> (rsp_complement == '0))
      else $error("no-solution word carries a complement");
`endif

endmodule
